@@ rtl/gsh_pkg.sv @@
// shared constants, payload types and helpers of the grid spatial hash engine
package gsh_pkg;

    localparam int BUCKETS    = 1024;
    localparam int POOL_DEPTH = 1024;
    localparam int MAX_HITS   = 64;

    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int ENT_W   = $clog2(POOL_DEPTH);
    localparam int USE_W   = ENT_W + 1;
    localparam int SWEEP_N = (BUCKETS > POOL_DEPTH) ? BUCKETS : POOL_DEPTH;
    localparam int SWP_W   = $clog2(SWEEP_N);
    localparam int LOOP_W  = SWP_W + 1;
    localparam int NWK_W   = BKT_W + 1;
    localparam int TAG_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [31:0] HASH_MUL_X = 32'd92821;
    localparam logic [31:0] HASH_MUL_Y = 32'd689287;
    localparam logic signed [31:0] EDGE_MAX = 32'sh7FFF_FFFF;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_CAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RES  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        item_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0]        size_w;
        logic [30:0]        size_h;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic        hit_valid;
        logic [15:0] hit_id;
        logic [6:0]  hit_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        obj_id;
        logic signed [31:0] left;
        logic signed [31:0] bottom;
        logic [30:0]        width;
        logic [30:0]        height;
        logic               link_valid;
        logic [ENT_W-1:0]   link;
    } t_entry;

    typedef struct packed {
        logic             valid;
        logic [ENT_W-1:0] head;
    } t_bucket;

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_FAR, ST_MUL, ST_SPAN, ST_TAG,
        ST_INS_CELL, ST_INS_WR, ST_Q_CELL, ST_Q_CHK, ST_Q_ENT, ST_Q_HIT,
        ST_Q_FIN, ST_DONE
    } t_state;

    function automatic logic signed [31:0] far_edge(input logic signed [31:0] pos,
                                                    input logic [30:0] size);
        logic [32:0] sum;
        sum = {pos[31], pos} + {2'b00, size};
        if (!sum[32] && sum[31]) begin
            far_edge = EDGE_MAX;
        end else begin
            far_edge = signed'(sum[31:0]);
        end
    endfunction

endpackage

@@ rtl/gsh_mul.sv @@
// shared signed multiplier with registered product
module gsh_mul import gsh_pkg::*; (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);

    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

@@ rtl/grid_spatial_hash_engine_unit.sv @@
// top level of the grid spatial hash engine
// Uniform-grid spatial hash over Q16.16 boxes. After reset a clearing pass runs before
// the first transaction is taken. A clear sweeps one bucket per cycle. Insert and query
// first compute far edges, cell bounds and hash seeds through the one shared multiplier,
// and a query then opens its marks. An insert then does a bucket read and then an entry
// and bucket write for each overlapped cell. A query reads the bucket and its mark for
// each overlapped cell and walks each chain not yet walked entry by entry, and the query
// that finds the mark tag used up (the 256th, then every 255th) adds a pass that clears
// the per-query marks. One transaction is in work at a time and results wait in an
// output register.
module grid_spatial_hash_engine_unit import gsh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

    localparam logic [2:0] MS_X0 = 3'd0;
    localparam logic [2:0] MS_X1 = 3'd1;
    localparam logic [2:0] MS_Y0 = 3'd2;
    localparam logic [2:0] MS_Y1 = 3'd3;
    localparam logic [2:0] MS_HX = 3'd4;
    localparam logic [2:0] MS_HY = 3'd5;

    t_state r_state, n_state;

    logic [31:0] r_inv;
    logic [10:0] r_pool_cap;
    logic [6:0]  r_max_res;

    t_in_item           r_item;
    logic signed [31:0] r_fx, r_fy, r_x0, r_x1, r_y0, r_y1;
    logic [31:0]        r_hx0, r_hx, r_hy;
    logic [32:0]        r_colsm1, r_rowsm1;
    logic [LOOP_W-1:0]  r_c, r_r;
    logic [2:0]         r_ms;
    logic [USE_W-1:0]   r_used;
    logic               r_status;
    logic [TAG_W-1:0]   r_epoch;
    logic [6:0]         r_count;
    logic [NWK_W-1:0]   r_nwalk;
    logic               r_pend_v;
    logic [15:0]        r_pend_id;
    logic [6:0]         r_pend_cnt;
    logic               r_out_v;
    t_out_item          r_out;
    logic [SWP_W-1:0]   r_sw;
    logic               r_sw_bkt, r_sw_tag;
    t_state             r_sw_ret;
    logic [BKT_W-1:0]   r_bkt;
    logic signed [31:0] r_efx, r_efy;
    logic               r_lt_ok;

    t_bucket          r_bkt_rd;
    t_entry           r_ent_rd;
    logic [TAG_W-1:0] r_walk_rd, r_seen_rd;

    t_bucket          bucket_mem [BUCKETS];
    t_entry           entry_mem  [POOL_DEPTH];
    logic [TAG_W-1:0] walk_mem   [BUCKETS];
    logic [TAG_W-1:0] seen_mem   [POOL_DEPTH];

    logic [USE_W-1:0]   w_cap;
    logic [6:0]         w_lim;
    logic [31:0]        w_hash;
    logic [BKT_W-1:0]   w_bkt;
    logic               w_out_free;
    logic               w_last_cell, w_col_end, w_sw_end;
    logic [ENT_W-1:0]   w_eid_idx;
    logic               w_hit, w_hit_wait;
    logic [6:0]         w_cnt_nx;
    logic signed [32:0] w_mul_a, w_mul_b;
    logic signed [65:0] w_prod;
    logic [32:0]        w_dx, w_dy;

    logic             w_bkt_re, w_bkt_we;
    logic [BKT_W-1:0] w_bkt_wa;
    t_bucket          w_bkt_wd;
    logic             w_ent_re, w_ent_we;
    logic [ENT_W-1:0] w_ent_ra;
    t_entry           w_ent_wd;
    logic             w_walk_re, w_walk_we;
    logic [BKT_W-1:0] w_walk_wa;
    logic [TAG_W-1:0] w_walk_wd;
    logic             w_seen_re, w_seen_we;
    logic [ENT_W-1:0] w_seen_wa;
    logic [TAG_W-1:0] w_seen_wd;
    logic             w_emit, w_adv;
    t_out_item        w_emit_data;

    gsh_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign w_cap = (32'(r_pool_cap) < 32'(POOL_DEPTH)) ? USE_W'(r_pool_cap)
                                                       : USE_W'(POOL_DEPTH);
    assign w_lim = (32'(r_max_res) < 32'(MAX_HITS)) ? r_max_res : 7'(MAX_HITS);
    assign w_hash = r_hx ^ r_hy;
    assign w_bkt = w_hash[BKT_W-1:0];
    assign w_out_free = !r_out_v || !i_out_stall;
    assign w_col_end = (33'(r_c) == r_colsm1);
    assign w_last_cell = w_col_end && (33'(r_r) == r_rowsm1);
    assign w_sw_end = (r_sw == SWP_W'(SWEEP_N - 1));
    assign w_eid_idx = r_ent_rd.obj_id[ENT_W-1:0];
    assign w_hit = r_lt_ok && (r_efx > r_item.pos_x) && (r_efy > r_item.pos_y)
                   && (32'(r_ent_rd.obj_id) < 32'(w_cap)) && (r_seen_rd != r_epoch);
    assign w_hit_wait = w_hit && r_pend_v && !w_out_free;
    assign w_cnt_nx = r_count + 7'(w_hit);
    assign w_dx = {r_x1[31], r_x1} - {r_x0[31], r_x0};
    assign w_dy = {r_y1[31], r_y1} - {r_y0[31], r_y0};

    assign w_ent_wd = '{obj_id: r_item.item_id, left: r_item.pos_x, bottom: r_item.pos_y,
                        width: r_item.size_w, height: r_item.size_h,
                        link_valid: r_bkt_rd.valid, link: r_bkt_rd.head};

    always_comb begin
        w_mul_b = {1'b0, r_inv};
        case (r_ms)
            MS_X0:   w_mul_a = {r_item.pos_x[31], r_item.pos_x};
            MS_X1:   w_mul_a = {r_fx[31], r_fx};
            MS_Y0:   w_mul_a = {r_item.pos_y[31], r_item.pos_y};
            MS_Y1:   w_mul_a = {r_fy[31], r_fy};
            MS_HX: begin
                w_mul_a = {r_x0[31], r_x0};
                w_mul_b = {1'b0, HASH_MUL_X};
            end
            MS_HY: begin
                w_mul_a = {r_y0[31], r_y0};
                w_mul_b = {1'b0, HASH_MUL_Y};
            end
            default: w_mul_a = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_bkt_re    = 1'b0;
        w_bkt_we    = 1'b0;
        w_bkt_wa    = r_bkt;
        w_bkt_wd    = '0;
        w_ent_re    = 1'b0;
        w_ent_we    = 1'b0;
        w_ent_ra    = r_bkt_rd.head;
        w_walk_re   = 1'b0;
        w_walk_we   = 1'b0;
        w_walk_wa   = r_bkt;
        w_walk_wd   = r_epoch;
        w_seen_re   = 1'b0;
        w_seen_we   = 1'b0;
        w_seen_wa   = w_eid_idx;
        w_seen_wd   = r_epoch;
        w_emit      = 1'b0;
        w_emit_data = '0;
        w_adv       = 1'b0;
        case (r_state)
            ST_SWEEP: begin
                w_bkt_we  = r_sw_bkt && (32'(r_sw) < 32'(BUCKETS));
                w_bkt_wa  = r_sw[BKT_W-1:0];
                w_walk_we = r_sw_tag && (32'(r_sw) < 32'(BUCKETS));
                w_walk_wa = r_sw[BKT_W-1:0];
                w_walk_wd = '0;
                w_seen_we = r_sw_tag && (32'(r_sw) < 32'(POOL_DEPTH));
                w_seen_wa = r_sw[ENT_W-1:0];
                w_seen_wd = '0;
                if (w_sw_end) begin
                    n_state = r_sw_ret;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.kind)
                        KIND_CLEAR:              n_state = ST_SWEEP;
                        KIND_INSERT, KIND_QUERY: n_state = ST_FAR;
                        default:                 n_state = ST_DONE;
                    endcase
                end
            end
            ST_FAR: n_state = ST_MUL;
            ST_MUL: begin
                if (r_ms == MS_HY + 3'd1) begin
                    n_state = ST_SPAN;
                end
            end
            ST_SPAN: n_state = (r_item.kind == KIND_INSERT) ? ST_INS_CELL : ST_TAG;
            ST_TAG:  n_state = (r_epoch == '1) ? ST_SWEEP : ST_Q_CELL;
            ST_INS_CELL: begin
                if (r_used >= w_cap) begin
                    n_state = ST_DONE;
                end else begin
                    w_bkt_re = 1'b1;
                    n_state  = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                w_ent_we = 1'b1;
                w_bkt_we = 1'b1;
                w_bkt_wd = '{valid: 1'b1, head: r_used[ENT_W-1:0]};
                w_adv    = 1'b1;
                n_state  = w_last_cell ? ST_DONE : ST_INS_CELL;
            end
            ST_Q_CELL: begin
                if (r_count >= w_lim || r_nwalk == NWK_W'(BUCKETS)) begin
                    n_state = ST_Q_FIN;
                end else begin
                    w_bkt_re  = 1'b1;
                    w_walk_re = 1'b1;
                    n_state   = ST_Q_CHK;
                end
            end
            ST_Q_CHK: begin
                if (r_walk_rd == r_epoch) begin
                    w_adv   = 1'b1;
                    n_state = w_last_cell ? ST_Q_FIN : ST_Q_CELL;
                end else begin
                    w_walk_we = 1'b1;
                    if (r_bkt_rd.valid) begin
                        w_ent_re = 1'b1;
                        n_state  = ST_Q_ENT;
                    end else begin
                        w_adv   = 1'b1;
                        n_state = w_last_cell ? ST_Q_FIN : ST_Q_CELL;
                    end
                end
            end
            ST_Q_ENT: begin
                w_seen_re = 1'b1;
                n_state   = ST_Q_HIT;
            end
            ST_Q_HIT: begin
                if (!w_hit_wait) begin
                    if (w_hit) begin
                        w_seen_we = 1'b1;
                        if (r_pend_v) begin
                            w_emit                = 1'b1;
                            w_emit_data.hit_valid = 1'b1;
                            w_emit_data.hit_id    = r_pend_id;
                            w_emit_data.hit_count = r_pend_cnt;
                        end
                    end
                    if (w_cnt_nx < w_lim && r_ent_rd.link_valid) begin
                        w_ent_re = 1'b1;
                        w_ent_ra = r_ent_rd.link;
                        n_state  = ST_Q_ENT;
                    end else begin
                        w_adv   = 1'b1;
                        n_state = w_last_cell ? ST_Q_FIN : ST_Q_CELL;
                    end
                end
            end
            ST_Q_FIN: begin
                if (w_out_free) begin
                    w_emit                = 1'b1;
                    w_emit_data.hit_valid = r_pend_v;
                    w_emit_data.hit_id    = r_pend_v ? r_pend_id : 16'd0;
                    w_emit_data.hit_count = r_pend_v ? r_pend_cnt : 7'd0;
                    w_emit_data.last      = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_emit             = 1'b1;
                    w_emit_data.status = r_status;
                    w_emit_data.last   = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv      <= 32'd65536;
            r_pool_cap <= 11'd1024;
            r_max_res  <= 7'd64;
            r_sw       <= '0;
            r_sw_bkt   <= 1'b1;
            r_sw_tag   <= 1'b1;
            r_sw_ret   <= ST_IDLE;
            r_epoch    <= '0;
            r_used     <= '0;
            r_out_v    <= 1'b0;
            r_pend_v   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INV_CELL: r_inv      <= i_cfg_data;
                    CFG_POOL_CAP: r_pool_cap <= i_cfg_data[10:0];
                    CFG_MAX_RES:  r_max_res  <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (w_emit) begin
                r_out_v <= 1'b1;
                r_out   <= w_emit_data;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_SWEEP: begin
                    r_sw <= r_sw + 1'b1;
                    if (w_sw_end) begin
                        r_sw     <= '0;
                        r_sw_bkt <= 1'b0;
                        r_sw_tag <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_item   <= i_in_data;
                        r_status <= 1'b0;
                        if (i_in_data.kind == KIND_CLEAR) begin
                            r_used   <= '0;
                            r_sw_bkt <= 1'b1;
                            r_sw_ret <= ST_DONE;
                        end
                    end
                end
                ST_FAR: begin
                    r_fx <= far_edge(r_item.pos_x, r_item.size_w);
                    r_fy <= far_edge(r_item.pos_y, r_item.size_h);
                    r_ms <= MS_X0;
                end
                ST_MUL: begin
                    r_ms <= r_ms + 3'd1;
                    case (r_ms)
                        MS_X0 + 3'd1: r_x0  <= w_prod[63:32];
                        MS_X1 + 3'd1: r_x1  <= w_prod[63:32];
                        MS_Y0 + 3'd1: r_y0  <= w_prod[63:32];
                        MS_Y1 + 3'd1: r_y1  <= w_prod[63:32];
                        MS_HX + 3'd1: r_hx0 <= w_prod[31:0];
                        MS_HY + 3'd1: r_hy  <= w_prod[31:0];
                        default: ;
                    endcase
                end
                ST_SPAN: begin
                    r_hx     <= r_hx0;
                    r_c      <= '0;
                    r_r      <= '0;
                    r_count  <= '0;
                    r_nwalk  <= '0;
                    r_pend_v <= 1'b0;
                    r_colsm1 <= w_dx;
                    r_rowsm1 <= w_dy;
                    if (r_item.kind == KIND_QUERY) begin
                        if (w_dx >= 33'(BUCKETS - 1)) begin
                            r_colsm1 <= 33'(BUCKETS - 1);
                            r_rowsm1 <= '0;
                        end else if (w_dy > 33'(BUCKETS - 1)) begin
                            r_rowsm1 <= 33'(BUCKETS - 1);
                        end
                    end
                end
                ST_TAG: begin
                    if (r_epoch == '1) begin
                        r_epoch  <= TAG_W'(1);
                        r_sw_tag <= 1'b1;
                        r_sw_ret <= ST_Q_CELL;
                    end else begin
                        r_epoch <= r_epoch + 1'b1;
                    end
                end
                ST_INS_CELL: begin
                    r_bkt <= w_bkt;
                    if (r_used >= w_cap) begin
                        r_status <= 1'b1;
                    end
                end
                ST_INS_WR: r_used <= r_used + 1'b1;
                ST_Q_CELL: r_bkt <= w_bkt;
                ST_Q_CHK: begin
                    if (w_walk_we) begin
                        r_nwalk <= r_nwalk + 1'b1;
                    end
                end
                ST_Q_ENT: begin
                    r_efx   <= far_edge(r_ent_rd.left, r_ent_rd.width);
                    r_efy   <= far_edge(r_ent_rd.bottom, r_ent_rd.height);
                    r_lt_ok <= (r_ent_rd.left < r_fx) && (r_ent_rd.bottom < r_fy);
                end
                ST_Q_HIT: begin
                    if (w_hit && !w_hit_wait) begin
                        r_count    <= w_cnt_nx;
                        r_pend_v   <= 1'b1;
                        r_pend_id  <= r_ent_rd.obj_id;
                        r_pend_cnt <= w_cnt_nx;
                    end
                end
                default: ;
            endcase
            if (w_adv) begin
                if (w_col_end) begin
                    r_c  <= '0;
                    r_r  <= r_r + 1'b1;
                    r_hx <= r_hx0;
                    r_hy <= r_hy + HASH_MUL_Y;
                end else begin
                    r_c  <= r_c + 1'b1;
                    r_hx <= r_hx + HASH_MUL_X;
                end
            end
        end
    end

    // bucket heads
    always_ff @(posedge i_clk) begin
        if (w_bkt_we) begin
            bucket_mem[w_bkt_wa] <= w_bkt_wd;
        end
        if (w_bkt_re) begin
            r_bkt_rd <= bucket_mem[w_bkt];
        end
    end

    // entry pool
    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            entry_mem[r_used[ENT_W-1:0]] <= w_ent_wd;
        end
        if (w_ent_re) begin
            r_ent_rd <= entry_mem[w_ent_ra];
        end
    end

    // per-query bucket marks
    always_ff @(posedge i_clk) begin
        if (w_walk_we) begin
            walk_mem[w_walk_wa] <= w_walk_wd;
        end
        if (w_walk_re) begin
            r_walk_rd <= walk_mem[w_bkt];
        end
    end

    // per-query id marks
    always_ff @(posedge i_clk) begin
        if (w_seen_we) begin
            seen_mem[w_seen_wa] <= w_seen_wd;
        end
        if (w_seen_re) begin
            r_seen_rd <= seen_mem[w_eid_idx];
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

@@ rtl/gsh_chk.sv @@
// port-level checker of the grid spatial hash engine and its bind
module gsh_chk import gsh_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input t_in_item             i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_item            o_out_data,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [31:0]          i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("new transaction taken while one is in work");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit_valid) |->
        (o_out_data.hit_id == 16'd0 && o_out_data.hit_count == 7'd0 && o_out_data.last))
        else $error("result without hit carries hit fields");

    a_hit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.hit_valid) |->
        (!o_out_data.status && o_out_data.hit_count != 7'd0
         && 32'(o_out_data.hit_count) <= 32'(MAX_HITS)))
        else $error("hit result with bad status or count");

endmodule

bind grid_spatial_hash_engine_unit gsh_chk u_gsh_chk (.*);
